[design/segtri_pkg.sv]
`default_nettype none
package segtri_pkg;

  // Coordinate format: signed Q8.8
  localparam int CW    = 16;
  localparam int IDX_W = 2;
  localparam int REG_W = 3 * CW;

  // Vertex and segment differences
  localparam int DW  = CW + 1;
  // Products of two differences, and the normal / squared-length sums
  localparam int NPW = 2 * DW;
  localparam int NW  = NPW + 1;
  // Plane dot products
  localparam int PPW = NW + DW;
  localparam int AW  = PPW + 1;
  // Magnitude bound of the plane numerator and denominator
  localparam int ABW = 3 * CW + 3;
  // Split point of the numerator for the scaling multiply
  localparam int SPL = (ABW + 1) / 2;
  // Division remainder and quotient
  localparam int RW  = ABW + CW;
  localparam int QW  = CW + 1;

  // Barycentric dot products and the split multiplier
  localparam int BW  = NW;
  localparam int MW  = BW;
  localparam int ML  = (MW + 1) / 2;
  localparam int MPW = 2 * MW;
  localparam int SW  = MPW + 2;

  typedef enum logic [IDX_W-1:0] {
    REG_VERTEX_A = 2'd0,
    REG_VERTEX_B = 2'd1,
    REG_VERTEX_C = 2'd2
  } reg_idx_t;

endpackage
`default_nettype wire

[design/segtri_mul.sv]
`default_nettype none
module segtri_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [segtri_pkg::MW-1:0]    a,
  input  logic signed [segtri_pkg::MW-1:0]    b,
  output logic signed [segtri_pkg::MPW-1:0]   p
);
  import segtri_pkg::*;

  logic signed [MW-ML-1:0]   ah, bh;
  logic        [ML-1:0]      al, bl;
  logic signed [2*(MW-ML)-1:0] hh_r;
  logic signed [MW+1:0]      hl_r, lh_r;
  logic        [2*ML-1:0]    ll_r;
  logic signed [MPW-1:0]     p_r;

  // Split each operand into a signed high half and an unsigned low half
  assign ah = a[MW-1:ML];
  assign al = a[ML-1:0];
  assign bh = b[MW-1:ML];
  assign bl = b[ML-1:0];

  // Register the partial products, then register their sum
  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= ah * bh;
      hl_r <= ah * $signed({1'b0, bl});
      lh_r <= $signed({1'b0, al}) * bh;
      ll_r <= al * bl;
      p_r  <= (MPW'(hh_r) << (2 * ML)) + ((MPW'(hl_r) + MPW'(lh_r)) << ML) + MPW'(ll_r);
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

[design/segment_triangle_intersect_unit.sv]
`default_nettype none
// Segment against triangle intersection test, fully pipelined.
// Configuration: cfg_we writes cfg_data into the vertex register picked by
// cfg_index (0: vertex A, 1: vertex B, 2: vertex C, other indices ignored).
// Each vertex is packed z:y:x, signed Q8.8. Write vertices only while no
// request is in flight; a request taken in the following cycle sees them.
// Input channel: in_valid / in_stall carry one segment (start and end point)
// per request. Result channel: out_valid / out_stall carry hit, point_valid
// and the crossing point (zero when point_valid is low).
// One request per cycle while the receiver does not stall. The pipeline
// depth is set by the 17-step restoring divider that forms the crossing
// point, one quotient bit per stage.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises; nothing is lost or repeated. Reset clears the vertex
// registers and every stage valid bit.
module segment_triangle_intersect_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [segtri_pkg::IDX_W-1:0]      cfg_index,
  input  logic [segtri_pkg::REG_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [segtri_pkg::CW-1:0]  in_start_x,
  input  logic signed [segtri_pkg::CW-1:0]  in_start_y,
  input  logic signed [segtri_pkg::CW-1:0]  in_start_z,
  input  logic signed [segtri_pkg::CW-1:0]  in_end_x,
  input  logic signed [segtri_pkg::CW-1:0]  in_end_y,
  input  logic signed [segtri_pkg::CW-1:0]  in_end_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic                              out_point_valid,
  output logic signed [segtri_pkg::CW-1:0]  out_cross_x,
  output logic signed [segtri_pkg::CW-1:0]  out_cross_y,
  output logic signed [segtri_pkg::CW-1:0]  out_cross_z
);
  import segtri_pkg::*;

  localparam int ST_ABS  = 3;
  localparam int ST_MISS = 7;
  localparam int ST_RND  = 9 + CW + 2;
  localparam int ST_CP   = ST_RND + 1;
  localparam int NS      = ST_CP + 9;

  // ---------------------------------------------------------------- config
  logic [REG_W-1:0] vtx_a_r, vtx_b_r, vtx_c_r;
  logic signed [CW-1:0] va [3], vb [3], vc [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtx_a_r <= '0;
      vtx_b_r <= '0;
      vtx_c_r <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_VERTEX_A: vtx_a_r <= cfg_data;
        REG_VERTEX_B: vtx_b_r <= cfg_data;
        REG_VERTEX_C: vtx_c_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      va[ax] = vtx_a_r[ax*CW +: CW];
      vb[ax] = vtx_b_r[ax*CW +: CW];
      vc[ax] = vtx_c_r[ax*CW +: CW];
    end
  end

  // ------------------------------------------- triangle terms from vertices
  logic signed [DW-1:0]  e1_r [3], e2_r [3], u_r [3], v_r [3];
  logic signed [NPW-1:0] np_r [6], uup_r [3], uvp_r [3], vvp_r [3];
  logic signed [NW-1:0]  n_r [3];
  logic signed [BW-1:0]  uu_r, uv_r, vv_r;
  logic signed [MPW-1:0] den_p0, den_p1;
  logic signed [SW-1:0]  den_r, den_abs_r;
  logic                  den_neg_r, den_zero_r;

  // Edge vectors, then products, then the normal and squared lengths
  always_ff @(posedge clk) begin
    for (int ax = 0; ax < 3; ax++) begin
      e1_r[ax]  <= DW'(va[ax]) - DW'(vb[ax]);
      e2_r[ax]  <= DW'(vc[ax]) - DW'(vb[ax]);
      u_r[ax]   <= DW'(vb[ax]) - DW'(va[ax]);
      v_r[ax]   <= DW'(vc[ax]) - DW'(va[ax]);
      uup_r[ax] <= u_r[ax] * u_r[ax];
      uvp_r[ax] <= u_r[ax] * v_r[ax];
      vvp_r[ax] <= v_r[ax] * v_r[ax];
      n_r[ax]   <= NW'(np_r[2*ax]) - NW'(np_r[2*ax+1]);
    end
    np_r[0] <= e1_r[1] * e2_r[2];
    np_r[1] <= e1_r[2] * e2_r[1];
    np_r[2] <= e1_r[2] * e2_r[0];
    np_r[3] <= e1_r[0] * e2_r[2];
    np_r[4] <= e1_r[0] * e2_r[1];
    np_r[5] <= e1_r[1] * e2_r[0];
    uu_r <= BW'(uup_r[0]) + BW'(uup_r[1]) + BW'(uup_r[2]);
    uv_r <= BW'(uvp_r[0]) + BW'(uvp_r[1]) + BW'(uvp_r[2]);
    vv_r <= BW'(vvp_r[0]) + BW'(vvp_r[1]) + BW'(vvp_r[2]);
    den_r      <= SW'(den_p0) - SW'(den_p1);
    den_neg_r  <= den_r[SW-1];
    den_zero_r <= (den_r == '0);
    den_abs_r  <= den_r[SW-1] ? -den_r : den_r;
  end

  segtri_mul u_mul_den0 (.clk(clk), .en(1'b1), .a(uv_r), .b(uv_r), .p(den_p0));
  segtri_mul u_mul_den1 (.clk(clk), .en(1'b1), .a(uu_r), .b(vv_r), .p(den_p1));

  // ---------------------------------------------------------- flow control
  logic [NS:1] vld_r;
  logic        adv;

  assign adv       = !(vld_r[NS] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r[1] <= in_valid;
      for (int s = 2; s <= NS; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  // ------------------------------------------------------------ item path
  logic signed [CW-1:0]  in_p1 [3], in_p2 [3];
  logic signed [CW-1:0]  s1_p2_r [3];
  logic signed [CW-1:0]  p1_c_r [3][1:ST_RND];
  logic                  dneg_c_r [3][ST_ABS:ST_RND];
  logic        [CW-1:0]  m_c_r [3][ST_ABS:ST_MISS];
  logic                  miss_c_r [ST_MISS:NS-1];
  logic signed [CW-1:0]  cp_c_r [3][ST_CP:NS-1];
  logic signed [DW-1:0]  s2_dir_r [3], s2_w0_r [3], s3_dir_r [3], s3_w0_r [3];
  logic signed [PPW-1:0] s4_pa_r [3], s4_pb_r [3];
  logic signed [AW-1:0]  s5_a_r, s5_b_r, s6_a_r, s6_b_r;
  logic                  s6_bz_r;
  logic        [ABW-1:0] s7_a_r, s7_b_r, s8_b_r;
  logic        [SPL+CW-1:0]     s8_lo_r [3];
  logic        [ABW-SPL+CW-1:0] s8_hi_r [3];
  logic        [RW-1:0]  rem_r [3][CW+2];
  logic        [QW-1:0]  q_r [3][CW+2];
  logic        [ABW-1:0] bd_r [CW+2];
  logic        [QW-1:0]  qr_r [3];
  logic        [QW:0]    cpx [3];
  logic signed [DW-1:0]  w_r [3];
  logic signed [NPW-1:0] wup_r [3], wvp_r [3];
  logic signed [BW-1:0]  wu_r, wv_r;
  logic signed [MPW-1:0] m_sn0, m_sn1, m_tn0, m_tn1;
  logic signed [SW-1:0]  sn_r, tn_r, sn2_r, tn2_r;
  logic signed [SW:0]    st_r;
  logic                  sn_ok_r, tn_ok_r;
  logic                  out_hit_r, out_point_valid_r;
  logic signed [CW-1:0]  out_cross_r [3];

  assign in_p1[0] = in_start_x;
  assign in_p1[1] = in_start_y;
  assign in_p1[2] = in_start_z;
  assign in_p2[0] = in_end_x;
  assign in_p2[1] = in_end_y;
  assign in_p2[2] = in_end_z;

  // Crossing coordinate: start plus or minus the rounded quotient
  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      cpx[ax] = dneg_c_r[ax][ST_RND] ? ((QW+1)'(p1_c_r[ax][ST_RND]) - (QW+1)'(qr_r[ax]))
                                     : ((QW+1)'(p1_c_r[ax][ST_RND]) + (QW+1)'(qr_r[ax]));
    end
  end

  // Advance the capture, plane test, scaling, rounding and barycentric stages
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ax = 0; ax < 3; ax++) begin
        // capture, differences, magnitudes
        p1_c_r[ax][1] <= in_p1[ax];
        s1_p2_r[ax]   <= in_p2[ax];
        for (int s = 2; s <= ST_RND; s++) p1_c_r[ax][s] <= p1_c_r[ax][s-1];
        s2_dir_r[ax] <= DW'(s1_p2_r[ax]) - DW'(p1_c_r[ax][1]);
        s2_w0_r[ax]  <= DW'(p1_c_r[ax][1]) - DW'(va[ax]);
        s3_dir_r[ax] <= s2_dir_r[ax];
        s3_w0_r[ax]  <= s2_w0_r[ax];
        dneg_c_r[ax][ST_ABS] <= s2_dir_r[ax][DW-1];
        m_c_r[ax][ST_ABS]    <= s2_dir_r[ax][DW-1] ? CW'(-s2_dir_r[ax]) : CW'(s2_dir_r[ax]);
        for (int s = ST_ABS + 1; s <= ST_RND; s++) dneg_c_r[ax][s] <= dneg_c_r[ax][s-1];
        for (int s = ST_ABS + 1; s <= ST_MISS; s++) m_c_r[ax][s] <= m_c_r[ax][s-1];
        // plane dot products
        s4_pa_r[ax] <= n_r[ax] * s3_w0_r[ax];
        s4_pb_r[ax] <= n_r[ax] * s3_dir_r[ax];
        // numerator times segment extent, in two halves
        s8_lo_r[ax] <= s7_a_r[SPL-1:0] * m_c_r[ax][ST_MISS];
        s8_hi_r[ax] <= s7_a_r[ABW-1:SPL] * m_c_r[ax][ST_MISS];
        // round the quotient to nearest, then place the point
        qr_r[ax] <= q_r[ax][CW+1]
                    + QW'({rem_r[ax][CW+1], 1'b0} >= (RW+1)'(bd_r[CW+1]));
        cp_c_r[ax][ST_CP] <= cpx[ax][CW-1:0];
        for (int s = ST_CP + 1; s <= NS - 1; s++) cp_c_r[ax][s] <= cp_c_r[ax][s-1];
        // barycentric dot products against the triangle edges
        w_r[ax]   <= DW'(cp_c_r[ax][ST_CP]) - DW'(va[ax]);
        wup_r[ax] <= w_r[ax] * u_r[ax];
        wvp_r[ax] <= w_r[ax] * v_r[ax];
        out_cross_r[ax] <= miss_c_r[NS-1] ? '0 : cp_c_r[ax][NS-1];
      end
      s5_a_r <= -(AW'(s4_pa_r[0]) + AW'(s4_pa_r[1]) + AW'(s4_pa_r[2]));
      s5_b_r <= AW'(s4_pb_r[0]) + AW'(s4_pb_r[1]) + AW'(s4_pb_r[2]);
      // make the denominator non-negative
      s6_a_r  <= s5_b_r[AW-1] ? -s5_a_r : s5_a_r;
      s6_b_r  <= s5_b_r[AW-1] ? -s5_b_r : s5_b_r;
      s6_bz_r <= (s5_b_r == '0);
      // drop parallel segments and parameters outside the unit range
      miss_c_r[ST_MISS] <= s6_bz_r || s6_a_r[AW-1] || (s6_a_r > s6_b_r);
      for (int s = ST_MISS + 1; s <= NS - 1; s++) miss_c_r[s] <= miss_c_r[s-1];
      s7_a_r <= s6_a_r[ABW-1:0];
      s7_b_r <= s6_b_r[ABW-1:0];
      s8_b_r <= s7_b_r;
      wu_r <= BW'(wup_r[0]) + BW'(wup_r[1]) + BW'(wup_r[2]);
      wv_r <= BW'(wvp_r[0]) + BW'(wvp_r[1]) + BW'(wvp_r[2]);
      // barycentric numerators, sign-matched to the denominator
      sn_r  <= SW'(m_sn0) - SW'(m_sn1);
      tn_r  <= SW'(m_tn0) - SW'(m_tn1);
      sn2_r <= den_neg_r ? -sn_r : sn_r;
      tn2_r <= den_neg_r ? -tn_r : tn_r;
      st_r    <= (SW+1)'(sn2_r) + (SW+1)'(tn2_r);
      sn_ok_r <= !sn2_r[SW-1] && (sn2_r <= den_abs_r);
      tn_ok_r <= !tn2_r[SW-1];
      out_point_valid_r <= !miss_c_r[NS-1];
      out_hit_r <= !miss_c_r[NS-1] && !den_zero_r && sn_ok_r && tn_ok_r
                   && (st_r <= (SW+1)'(den_abs_r));
    end
  end

  // Restoring divider: one quotient bit per stage for each axis
  for (genvar ax = 0; ax < 3; ax++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[ax][0] <= (RW'(s8_hi_r[ax]) << SPL) + RW'(s8_lo_r[ax]);
        q_r[ax][0]   <= '0;
        for (int i = 0; i <= CW; i++) begin
          if (rem_r[ax][i] >= (RW'(bd_r[i]) << (CW - i))) begin
            rem_r[ax][i+1] <= rem_r[ax][i] - (RW'(bd_r[i]) << (CW - i));
            q_r[ax][i+1]   <= q_r[ax][i] | (QW'(1) << (CW - i));
          end else begin
            rem_r[ax][i+1] <= rem_r[ax][i];
            q_r[ax][i+1]   <= q_r[ax][i];
          end
        end
      end
    end
  end

  // Carry the divisor alongside the remainders
  always_ff @(posedge clk) begin
    if (adv) begin
      bd_r[0] <= s8_b_r;
      for (int i = 1; i <= CW + 1; i++) bd_r[i] <= bd_r[i-1];
    end
  end

  segtri_mul u_mul_sn0 (.clk(clk), .en(adv), .a(uv_r), .b(wv_r), .p(m_sn0));
  segtri_mul u_mul_sn1 (.clk(clk), .en(adv), .a(vv_r), .b(wu_r), .p(m_sn1));
  segtri_mul u_mul_tn0 (.clk(clk), .en(adv), .a(uv_r), .b(wu_r), .p(m_tn0));
  segtri_mul u_mul_tn1 (.clk(clk), .en(adv), .a(uu_r), .b(wv_r), .p(m_tn1));

  assign out_hit         = out_hit_r;
  assign out_point_valid = out_point_valid_r;
  assign out_cross_x     = out_cross_r[0];
  assign out_cross_y     = out_cross_r[1];
  assign out_cross_z     = out_cross_r[2];

endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import segtri_pkg::*;

  localparam int            CLK_HALF   = 10;
  localparam int            CYCLE_CAP  = 200000;
  localparam int            SETTLE     = 48;
  localparam logic [IDX_W-1:0] IDX_SPARE = 2'd3;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
  } segment_t;

  typedef struct packed {
    logic                 hit;
    logic                 pv;
    logic signed [CW-1:0] cx, cy, cz;
  } crossing_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [IDX_W-1:0]     cfg_index;
  logic [REG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [CW-1:0] in_start_x, in_start_y, in_start_z;
  logic signed [CW-1:0] in_end_x, in_end_y, in_end_z;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_hit;
  logic                 out_point_valid;
  logic signed [CW-1:0] out_cross_x, out_cross_y, out_cross_z;

  // shadow copy of the vertex registers
  logic [REG_W-1:0] shadow_vtx [3];
  crossing_t        pending_crossings [$];
  int               fail_count;
  int               cycle_count;
  int               idle_in_pct;
  int               stall_out_pct;

  segment_triangle_intersect_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_start_x(in_start_x), .in_start_y(in_start_y), .in_start_z(in_start_z),
    .in_end_x(in_end_x), .in_end_y(in_end_y), .in_end_z(in_end_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hit(out_hit), .out_point_valid(out_point_valid),
    .out_cross_x(out_cross_x), .out_cross_y(out_cross_y), .out_cross_z(out_cross_z)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Work out the crossing and the hit flag for one segment
  function automatic crossing_t predict_crossing(segment_t s);
    longint    va[3], vb[3], vc[3], p[3], q[3], e1[3], e2[3], nv[3];
    longint    d[3], w0[3], cp[3], u[3], v[3], w[3];
    longint    uu, uv, vv, wu, wv, dd, mag;
    wide_t     num, den, quo, sn, tn, bden;
    crossing_t r;
    for (int k = 0; k < 3; k++) begin
      va[k] = $signed(shadow_vtx[0][k*CW +: CW]);
      vb[k] = $signed(shadow_vtx[1][k*CW +: CW]);
      vc[k] = $signed(shadow_vtx[2][k*CW +: CW]);
    end
    p[0] = s.sx; p[1] = s.sy; p[2] = s.sz;
    q[0] = s.ex; q[1] = s.ey; q[2] = s.ez;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      e1[k] = va[k] - vb[k];
      e2[k] = vc[k] - vb[k];
      d[k]  = q[k] - p[k];
      w0[k] = p[k] - va[k];
    end
    nv[0] = e1[1] * e2[2] - e1[2] * e2[1];
    nv[1] = e1[2] * e2[0] - e1[0] * e2[2];
    nv[2] = e1[0] * e2[1] - e1[1] * e2[0];
    num = -wide_t'(nv[0] * w0[0] + nv[1] * w0[1] + nv[2] * w0[2]);
    den = wide_t'(nv[0] * d[0] + nv[1] * d[1] + nv[2] * d[2]);
    // parallel, in-plane or degenerate: miss
    if (den == 0) return r;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num < 0 || num > den) return r;
    // round to nearest, ties away from zero
    for (int k = 0; k < 3; k++) begin
      dd    = d[k];
      mag   = (dd < 0) ? -dd : dd;
      quo   = (wide_t'(2) * wide_t'(mag) * num + den) / (wide_t'(2) * den);
      cp[k] = (dd < 0) ? p[k] - longint'(quo) : p[k] + longint'(quo);
    end
    r.pv = 1'b1;
    r.cx = cp[0][CW-1:0];
    r.cy = cp[1][CW-1:0];
    r.cz = cp[2][CW-1:0];
    for (int k = 0; k < 3; k++) begin
      u[k] = vb[k] - va[k];
      v[k] = vc[k] - va[k];
      w[k] = cp[k] - va[k];
    end
    uu = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
    uv = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    vv = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    wu = w[0] * u[0] + w[1] * u[1] + w[2] * u[2];
    wv = w[0] * v[0] + w[1] * v[1] + w[2] * v[2];
    sn   = wide_t'(uv) * wide_t'(wv) - wide_t'(vv) * wide_t'(wu);
    tn   = wide_t'(uv) * wide_t'(wu) - wide_t'(uu) * wide_t'(wv);
    bden = wide_t'(uv) * wide_t'(uv) - wide_t'(uu) * wide_t'(vv);
    if (bden == 0) return r;
    if (bden < 0) begin
      sn   = -sn;
      tn   = -tn;
      bden = -bden;
    end
    r.hit = (sn >= 0) && (sn <= bden) && (tn >= 0) && (sn + tn <= bden);
    return r;
  endfunction

  // Predict on every accepted request, compare every accepted result
  always @(posedge clk) begin
    crossing_t got, want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        pending_crossings.push_back(predict_crossing(
          {in_start_x, in_start_y, in_start_z, in_end_x, in_end_y, in_end_z}));
      if (out_valid && !out_stall) begin
        got = {out_hit, out_point_valid, out_cross_x, out_cross_y, out_cross_z};
        if (pending_crossings.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result %p", $time, got);
        end else begin
          want = pending_crossings.pop_front();
          if (got.hit !== want.hit) begin
            fail_count++;
            $display("%0t: hit exp %0b got %0b", $time, want.hit, got.hit);
          end
          if (got.pv !== want.pv) begin
            fail_count++;
            $display("%0t: point_valid exp %0b got %0b", $time, want.pv, got.pv);
          end
          if (got.cx !== want.cx) begin
            fail_count++;
            $display("%0t: cross_x exp %0d got %0d", $time, want.cx, got.cx);
          end
          if (got.cy !== want.cy) begin
            fail_count++;
            $display("%0t: cross_y exp %0d got %0d", $time, want.cy, got.cy);
          end
          if (got.cz !== want.cz) begin
            fail_count++;
            $display("%0t: cross_z exp %0d got %0d", $time, want.cz, got.cz);
          end
        end
      end
    end
  end

  // Receiver stalls at the current rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_out_pct);
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [REG_W-1:0] pack_vertex(int x, int y, int z);
    return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
  endfunction

  function automatic int rand_coord(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx < 3) shadow_vtx[idx] = data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_triangle(logic [REG_W-1:0] a, logic [REG_W-1:0] b,
                               logic [REG_W-1:0] c);
    write_reg(REG_VERTEX_A, a);
    write_reg(REG_VERTEX_B, b);
    write_reg(REG_VERTEX_C, c);
  endtask

  // Drop valid, hold until every expected result is back, then let the pipe settle
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_crossings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Send one request, with a random gap before it
  task automatic send_segment(segment_t s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_in_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_start_x <= s.sx; in_start_y <= s.sy; in_start_z <= s.sz;
    in_end_x   <= s.ex; in_end_y   <= s.ey; in_end_z   <= s.ez;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_pts(int sx, int sy, int sz, int ex, int ey, int ez);
    segment_t s;
    s.sx = sx[CW-1:0]; s.sy = sy[CW-1:0]; s.sz = sz[CW-1:0];
    s.ex = ex[CW-1:0]; s.ey = ey[CW-1:0]; s.ez = ez[CW-1:0];
    send_segment(s);
  endtask

  // Segments against a flat triangle in the z = 0 plane
  task automatic test_flat_triangle;
    load_triangle(pack_vertex(0, 0, 0), pack_vertex(1024, 0, 0), pack_vertex(0, 1024, 0));
    send_pts(256, 256, 512, 256, 256, -512);     // through the inside
    send_pts(0, 0, 256, 0, 0, -256);             // through a vertex
    send_pts(512, 512, 300, 512, 512, -100);     // on the hypotenuse
    send_pts(512, 0, -77, 512, 0, 33);           // on an edge, upward
    send_pts(2000, 2000, 100, 2000, 2000, -100); // outside the triangle
    send_pts(100, 100, 100, 900, 100, 100);      // parallel above the plane
    send_pts(100, 100, 0, 300, 200, 0);          // lying in the plane
    send_pts(100, 100, 500, 100, 100, 200);      // stops short of the plane
    send_pts(100, 100, 0, 100, 100, 300);        // starts on the plane
    send_pts(100, 100, 300, 100, 100, 0);        // ends on the plane
    send_pts(-1, -1, 1, -1, -1, -1);             // just outside a corner
    send_pts(3, 5, 1, 6, 2, -2);                 // exact crossing, no rounding
    send_pts(-32768, -32768, -32768, 32767, 32767, 32767);
    send_pts(32767, -32768, 32767, -32768, 32767, -32768);
    send_pts(0, 0, 0, 0, 0, 0);                  // zero-length segment
    drain;
  endtask

  // Collinear and coincident vertices give a zero normal
  task automatic test_degenerate;
    load_triangle(pack_vertex(0, 0, 0), pack_vertex(256, 256, 256),
                  pack_vertex(512, 512, 512));
    send_pts(0, 0, 100, 0, 0, -100);
    send_pts(-32768, 0, 32767, 32767, 0, -32768);
    drain;
    load_triangle(pack_vertex(77, 77, 77), pack_vertex(77, 77, 77), pack_vertex(77, 77, 77));
    send_pts(77, 77, 200, 77, 77, -200);
    drain;
  endtask

  // Vertex coordinates at the limits of the format, and an unused index
  task automatic test_extreme_vertices;
    load_triangle(pack_vertex(-32768, -32768, -32768), pack_vertex(32767, -32768, 0),
                  pack_vertex(-32768, 32767, 32767));
    write_reg(IDX_SPARE, '1);
    send_pts(-1000, -1000, -32768, -1000, -1000, 32767);
    send_pts(-32768, -32768, -32768, 32767, 32767, 32767);
    send_pts(0, 0, 32767, 0, 0, -32768);
    send_pts(32767, 32767, 32767, -32768, -32768, -32768);
    drain;
    load_triangle(pack_vertex(32767, 32767, 32767), pack_vertex(-32768, 32767, -32768),
                  pack_vertex(32767, -32768, -32768));
    send_pts(0, 0, 0, 32767, 32767, 32767);
    send_pts(-32768, 0, 0, 32767, 0, 0);
    drain;
  endtask

  // A segment through a point near the triangle, mostly crossing its plane
  task automatic send_random_segment(int span);
    int       ua[3], ub[3], uc[3], pt[3], off[3], st[3], en[3];
    int       fs, ft, kind, scale;
    segment_t s;
    kind = $urandom_range(99);
    if (kind < 15) begin
      s = {$urandom(), $urandom(), $urandom()};
      send_segment(s);
      return;
    end
    for (int k = 0; k < 3; k++) begin
      ua[k] = $signed(shadow_vtx[0][k*CW +: CW]);
      ub[k] = $signed(shadow_vtx[1][k*CW +: CW]);
      uc[k] = $signed(shadow_vtx[2][k*CW +: CW]);
    end
    fs    = $urandom_range(300);
    ft    = $urandom_range(300 - fs);
    scale = $urandom_range(3);
    for (int k = 0; k < 3; k++) begin
      pt[k]  = ua[k] + ((ub[k] - ua[k]) * fs + (uc[k] - ua[k]) * ft) / 256;
      off[k] = rand_coord(span);
      st[k]  = pt[k] + off[k];
      en[k]  = (kind < 30) ? st[k] + (ub[k] - uc[k]) : pt[k] - (off[k] * scale) / 2;
    end
    send_pts(st[0], st[1], st[2], en[0], en[1], en[2]);
  endtask

  // One idling phase with a fresh triangle every few requests
  task automatic test_random_phase(int in_pct, int out_pct, int count);
    int span;
    idle_in_pct   = in_pct;
    stall_out_pct = out_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 20 == 0) begin
        drain;
        span = ($urandom_range(3) == 0) ? 60 : 3000;
        load_triangle(pack_vertex(rand_coord(span), rand_coord(span), rand_coord(span)),
                      pack_vertex(rand_coord(span), rand_coord(span), rand_coord(span)),
                      pack_vertex(rand_coord(span), rand_coord(span), rand_coord(span)));
        if ($urandom_range(3) == 0) write_reg(IDX_SPARE, {$urandom(), $urandom()});
      end
      send_random_segment(span);
    end
    drain;
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_start_x    = '0; in_start_y = '0; in_start_z = '0;
    in_end_x      = '0; in_end_y   = '0; in_end_z   = '0;
    out_stall     = 1'b0;
    idle_in_pct   = 0;
    stall_out_pct = 0;
    fail_count    = 0;
    cycle_count   = 0;
    for (int k = 0; k < 3; k++) shadow_vtx[k] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // registers at reset value: every segment misses
    send_pts(10, 20, 30, -40, -50, -60);
    drain;
    test_flat_triangle;
    test_degenerate;
    test_extreme_vertices;
    test_random_phase(0, 0, 170);
    test_random_phase(57, 0, 170);
    test_random_phase(0, 57, 170);
    test_random_phase(30, 30, 170);
    drain;
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
design/segtri_pkg.sv
design/segtri_mul.sv
design/segment_triangle_intersect_unit.sv
verif/tb.sv
